// ----- src/assert_macros.svh -----
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- src/caft_pkg.sv -----
package caft_pkg;

  localparam int unsigned SEGMENT_BOUNDARY = 65536;
  localparam int unsigned BLOCK_BYTES      = 256;
  localparam int unsigned BLOCK_BITS       = $clog2(BLOCK_BYTES);
  localparam int unsigned PAIR_BYTES       = 2 * BLOCK_BYTES;
  localparam int unsigned KEY_BYTES        = 32;
  localparam int unsigned KEY_SEL_BITS     = $clog2(KEY_BYTES);
  localparam int unsigned ROT_B            = 7;
  localparam int unsigned ROT_D            = 11;
  localparam int unsigned CFG_INDEX_BITS   = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE      = 3'd0,
    REG_KEY0      = 3'd1,
    REG_KEY1      = 3'd2,
    REG_KEY2      = 3'd3,
    REG_KEY3      = 3'd4,
    REG_CHUNK_LEN = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_ARX   = 2'd1,
    MODE_BLOCK = 2'd2
  } mode_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Key byte n sits at bits 8n+7..8n of the flattened key.
  function automatic logic [7:0] key_byte(input logic [8*KEY_BYTES-1:0] key,
                                          input logic [KEY_SEL_BITS-1:0] n);
    return key[{n, 3'b000} +: 8];
  endfunction

endpackage

// ----- src/chunk_arx_feistel_transform_top.sv -----
// Chunk byte obfuscator.
// Channels: config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken
// every cycle and must come only while the block is idle. Chunk bytes enter on
// in_valid/in_ready with end_of_chunk on the final byte; results leave on
// out_valid/out_ready with their chunk offset and run_end on the last result
// of each input byte.
// An accepted byte is registered in the item stage, then in the output register.
// Throughput: one byte per cycle while the output does not stall and no pair
// is being sent. An odd block byte in paired block mode makes two results; the
// single output port sends them in turn. Even block bytes make no result and
// only write the block store. The ARX step has four 32-bit adds, three in series,
// and is combinational. The block store is a 256 x 8 RAM with a registered read,
// read only by odd block bytes and written only by even block bytes, so no entry
// is read and written in the same cycle.
// Reset: clears mode, key, length, byte offset and both pipeline stages. The
// store is not cleared.
// Stall: with out_ready low the output register holds, one more byte is taken
// into the item stage, then in_ready drops.
module chunk_arx_feistel_transform_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_chunk,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [31:0] out_position,
  output logic        run_end
);

  logic [1:0]   mode;
  logic [63:0]  key_word0, key_word1, key_word2, key_word3;
  logic [31:0]  chunk_length;
  logic [255:0] key_flat;

  logic [31:0] word_a, word_b, word_c, word_d;
  logic [31:0] byte_index;

  logic [7:0] store [caft_pkg::BLOCK_BYTES];
  logic [7:0] rd_data;

  // item stage
  logic        s1_valid;
  logic        s1_pair;
  logic        s1_sub;
  logic [7:0]  s1_byte;
  logic [31:0] s1_pos0;
  logic [31:0] s1_pos1;

  logic accept;
  logic out_load, s1_done;
  logic [7:0]  cur_byte;
  logic [31:0] cur_pos;
  logic        cur_last;

  logic [31:0] a_in, b_in, c_in, d_in;
  logic [31:0] a1, b_sum, b1, c1, d1;
  logic [7:0]  keystream;

  logic [31:0] limit, region;
  logic        in_region, odd_blk;
  logic [caft_pkg::BLOCK_BITS-1:0] j;
  logic [7:0]  r_byte, mask;
  logic        is_arx, is_block;
  logic        store_we, store_re, produce, produce_pair;
  logic [7:0]  res_byte;
  logic [31:0] res_pos0;

  assign key_flat  = {key_word3, key_word2, key_word1, key_word0};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= caft_pkg::MODE_PASS;
      key_word0    <= '0;
      key_word1    <= '0;
      key_word2    <= '0;
      key_word3    <= '0;
      chunk_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        caft_pkg::REG_MODE:      mode         <= cfg_data[1:0];
        caft_pkg::REG_KEY0:      key_word0    <= cfg_data;
        caft_pkg::REG_KEY1:      key_word1    <= cfg_data;
        caft_pkg::REG_KEY2:      key_word2    <= cfg_data;
        caft_pkg::REG_KEY3:      key_word3    <= cfg_data;
        caft_pkg::REG_CHUNK_LEN: chunk_length <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign is_arx   = (mode == caft_pkg::MODE_ARX);
  assign is_block = (mode == caft_pkg::MODE_BLOCK);

  // ARX words reload from the key at chunk offset 0
  always_comb begin
    if (byte_index == '0) begin
      a_in = key_flat[31:0];
      b_in = key_flat[63:32];
      c_in = key_flat[95:64];
      d_in = key_flat[127:96];
    end else begin
      a_in = word_a;
      b_in = word_b;
      c_in = word_c;
      d_in = word_d;
    end
    a1        = a_in + (b_in ^ byte_index);
    b_sum     = b_in + c_in + a1;
    b1        = caft_pkg::rotl(b_sum, caft_pkg::ROT_B);
    c1        = c_in ^ (d_in + b1);
    d1        = caft_pkg::rotl(d_in ^ a1 ^ c1, caft_pkg::ROT_D);
    keystream = a1[7:0] ^ b1[15:8] ^ c1[23:16] ^ d1[31:24];
  end

  // paired block region ends at the last whole pair below min(length, boundary)
  always_comb begin
    limit     = (chunk_length < 32'(caft_pkg::SEGMENT_BOUNDARY)) ?
                chunk_length : 32'(caft_pkg::SEGMENT_BOUNDARY);
    region    = limit & ~(32'(caft_pkg::PAIR_BYTES) - 32'd1);
    in_region = byte_index < region;
    odd_blk   = byte_index[caft_pkg::BLOCK_BITS];
    j         = byte_index[caft_pkg::BLOCK_BITS-1:0];
    r_byte    = caft_pkg::key_byte(key_flat,
                  {byte_index[caft_pkg::BLOCK_BITS+caft_pkg::KEY_SEL_BITS-1:
                              caft_pkg::BLOCK_BITS+1], 1'b0});
    mask      = caft_pkg::key_byte(key_flat,
                  caft_pkg::KEY_SEL_BITS'(8'(j) + r_byte)) + 8'(j);
  end

  assign accept       = in_valid && in_ready;
  assign store_we     = accept && is_block && in_region && !odd_blk;
  assign store_re     = accept && is_block && in_region && odd_blk;
  assign produce_pair = is_block && in_region && odd_blk;
  assign produce      = !(is_block && in_region && !odd_blk);

  always_comb begin
    res_pos0 = byte_index;
    if (is_arx) begin
      res_byte = data_byte ^ keystream;
    end else if (produce_pair) begin
      res_byte = data_byte ^ mask;
      res_pos0 = byte_index & ~32'(caft_pkg::BLOCK_BYTES);
    end else begin
      res_byte = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[j] <= data_byte ^ mask;
    end
    if (store_re) begin
      rd_data <= store[j];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_a <= is_arx ? a1 : a_in;
      word_b <= is_arx ? b1 : b_in;
      word_c <= is_arx ? c1 : c_in;
      word_d <= is_arx ? d1 : d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (accept) begin
      byte_index <= end_of_chunk ? '0 : byte_index + 32'd1;
    end
  end

  // second result of a pair comes from the store read
  assign cur_byte = s1_sub ? rd_data : s1_byte;
  assign cur_pos  = s1_sub ? s1_pos1 : s1_pos0;
  assign cur_last = !s1_pair || s1_sub;
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign s1_done  = out_load && cur_last;
  assign in_ready = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_sub   <= 1'b0;
    end else if (accept && produce) begin
      s1_valid <= 1'b1;
      s1_sub   <= 1'b0;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end else if (out_load) begin
      s1_sub   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      s1_pair <= produce_pair;
      s1_byte <= res_byte;
      s1_pos0 <= res_pos0;
      s1_pos1 <= byte_index;
    end
  end

  // output register: one result transaction per cycle while out_ready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte     <= cur_byte;
      out_position <= cur_pos;
      run_end      <= cur_last;
    end
  end

endmodule

// ----- src/caft_checker.sv -----
`include "assert_macros.svh"

module caft_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [31:0] out_position,
  input logic        run_end
);

  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  `ASSERT_CLK(a_out_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_position) && $stable(run_end))

  // first result of a pair is followed at once by its partner
  `ASSERT_CLK(a_pair_follow, clk, rst,
    out_valid && out_ready && !run_end |=> out_valid && run_end)

  // pair partners share the in-block offset, even block first
  `ASSERT_CLK(a_pair_pos, clk, rst,
    out_valid && out_ready && !run_end |=> out_position[8] && !$past(out_position[8]) &&
      out_position[7:0] == $past(out_position[7:0]))

endmodule

bind chunk_arx_feistel_transform_top caft_checker u_caft_checker (.*);

// ----- test/tb_chunk_arx_feistel_transform_top.sv -----
module tb_chunk_arx_feistel_transform_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [1:0]  MODE_SPARE    = 2'd3;  // unassigned encoding, behaves as pass

  typedef struct {
    logic [7:0]  value;
    logic [31:0] offset;
    logic        last;
  } chunk_result_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index    = '0;
  logic [63:0] cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte    = '0;
  logic        end_of_chunk = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  out_byte;
  logic [31:0] out_position;
  logic        run_end;

  chunk_arx_feistel_transform_top uut (.*);

  // predictor copy of registers and state
  logic [1:0]   cfg_mode      = caft_pkg::MODE_PASS;
  logic [255:0] key_flat      = '0;
  logic [31:0]  cfg_chunk_len = '0;
  logic [31:0]  ks_a = '0, ks_b = '0, ks_c = '0, ks_d = '0;
  logic [31:0]  chunk_offset  = '0;
  logic [7:0]   block_store [caft_pkg::BLOCK_BYTES];

  chunk_result_t transformed_q [$];
  chunk_result_t head_r;

  int unsigned cycle_count     = 0;
  int unsigned bytes_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned pair_chunks     = 0;
  int unsigned error_count     = 0;
  int unsigned idle_pct        = 0;
  int unsigned stall_pct       = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (transformed_q.size() == 0) begin
        $error("unexpected result: out_byte %02h out_position %0d", out_byte, out_position);
        error_count++;
      end else begin
        head_r = transformed_q.pop_front();
        results_checked++;
        if (out_byte !== head_r.value) begin
          $error("out_byte expected %02h actual %02h", head_r.value, out_byte);
          error_count++;
        end
        if (out_position !== head_r.offset) begin
          $error("out_position expected %0d actual %0d", head_r.offset, out_position);
          error_count++;
        end
        if (run_end !== head_r.last) begin
          $error("run_end expected %0b actual %0b", head_r.last, run_end);
          error_count++;
        end
      end
    end
  end

  function automatic logic [7:0] key_at(input logic [4:0] n);
    return key_flat[n*8 +: 8];
  endfunction

  function automatic logic [63:0] rand_key();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(3))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1023);
      default: return $urandom;
    endcase
  endfunction

  task automatic predict_transform(input logic [7:0] d, input logic eoc);
    logic [31:0]     p;
    logic [31:0]     ks;
    logic [7:0]      j;
    logic [7:0]      mask;
    int unsigned     blk;
    int unsigned     pair_blk;
    logic [31:0]     lim;
    logic [31:0]     region;
    p = chunk_offset;
    if (p == 0) begin
      ks_a = key_flat[31:0];
      ks_b = key_flat[63:32];
      ks_c = key_flat[95:64];
      ks_d = key_flat[127:96];
    end
    case (cfg_mode)
      caft_pkg::MODE_ARX: begin
        ks_a = ks_a + (ks_b ^ p);
        ks   = ks_b + ks_c + ks_a;
        ks_b = {ks[24:0], ks[31:25]};
        ks_c = ks_c ^ (ks_d + ks_b);
        ks   = ks_d ^ ks_a ^ ks_c;
        ks_d = {ks[20:0], ks[31:21]};
        ks   = ks_a ^ (ks_b >> 8) ^ (ks_c >> 16) ^ (ks_d >> 24);
        transformed_q.push_back('{d ^ ks[7:0], p, 1'b1});
      end
      caft_pkg::MODE_BLOCK: begin
        lim    = (cfg_chunk_len < caft_pkg::SEGMENT_BOUNDARY) ?
                 cfg_chunk_len : 32'(caft_pkg::SEGMENT_BOUNDARY);
        region = (lim / caft_pkg::BLOCK_BYTES / 2) * caft_pkg::PAIR_BYTES;
        if (p < region) begin
          blk      = p / caft_pkg::BLOCK_BYTES;
          j        = p[7:0];
          pair_blk = blk - (blk % 2);
          mask     = key_at(5'(j[4:0] + key_at(5'(pair_blk)))) + j;
          if (blk % 2 == 0) begin
            block_store[j] = d ^ mask;
          end else begin
            // odd block byte lands at the even block's place, held byte follows
            transformed_q.push_back('{d ^ mask,
                                      32'(pair_blk * caft_pkg::BLOCK_BYTES + j), 1'b0});
            transformed_q.push_back('{block_store[j], p, 1'b1});
          end
        end else begin
          transformed_q.push_back('{d, p, 1'b1});
        end
      end
      default: begin
        transformed_q.push_back('{d, p, 1'b1});
      end
    endcase
    chunk_offset = eoc ? 32'd0 : p + 32'd1;
  endtask

  task automatic write_reg(input caft_pkg::reg_index_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      caft_pkg::REG_MODE:      cfg_mode = val[1:0];
      caft_pkg::REG_KEY0:      key_flat[63:0] = val;
      caft_pkg::REG_KEY1:      key_flat[127:64] = val;
      caft_pkg::REG_KEY2:      key_flat[191:128] = val;
      caft_pkg::REG_KEY3:      key_flat[255:192] = val;
      caft_pkg::REG_CHUNK_LEN: cfg_chunk_len = val[31:0];
      default: ;
    endcase
  endtask

  // back-to-back transactions keep cfg_valid high; lowered once at the end
  task automatic load_config(input logic [1:0] m, input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [31:0] len);
    write_reg(caft_pkg::REG_MODE, {62'd0, m});
    write_reg(caft_pkg::REG_KEY0, k0);
    write_reg(caft_pkg::REG_KEY1, k1);
    write_reg(caft_pkg::REG_KEY2, k2);
    write_reg(caft_pkg::REG_KEY3, k3);
    write_reg(caft_pkg::REG_CHUNK_LEN, {32'd0, len});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] d, input logic eoc);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= d;
    end_of_chunk <= eoc;
    do @(posedge clk); while (!in_ready);
    predict_transform(d, eoc);
    bytes_sent++;
  endtask

  task automatic send_chunk(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // even block bytes give no result, so keep waiting past the queue draining
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (transformed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_pass();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_arx_extremes();
    wait_idle();
    load_config(caft_pkg::MODE_ARX, '1, '1, '1, '1, '0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b1);  // one-byte chunk, words reload
    wait_idle();
    load_config(caft_pkg::MODE_ARX, '0, '0, '0, '0, '1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_spare_mode();
    wait_idle();
    load_config(MODE_SPARE, rand_key(), rand_key(), rand_key(), rand_key(), 32'd4096);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);
  endtask

  task automatic test_block_edges();
    wait_idle();
    // no full pair: everything passes
    load_config(caft_pkg::MODE_BLOCK, rand_key(), rand_key(), rand_key(), rand_key(), 32'd0);
    send_chunk(2);
    wait_idle();
    load_config(caft_pkg::MODE_BLOCK, rand_key(), rand_key(), rand_key(), rand_key(), 32'd511);
    send_chunk(2);
    // chunk ends inside the even block: held bytes are dropped
    wait_idle();
    load_config(caft_pkg::MODE_BLOCK, rand_key(), rand_key(), rand_key(), rand_key(), 32'd512);
    send_chunk(4);
    wait_idle();
    load_config(caft_pkg::MODE_BLOCK, '1, '0, '1, '0, 32'hFFFF_FFFF);
    send_chunk(3);
  endtask

  task automatic run_block_pair();
    int unsigned total;
    logic [31:0] len_reg;
    total = caft_pkg::PAIR_BYTES + $urandom_range(24);
    case ($urandom_range(3))
      0: len_reg = total;
      1: len_reg = $urandom_range(caft_pkg::PAIR_BYTES, 3 * caft_pkg::BLOCK_BYTES - 1);
      2: len_reg = 32'hFFFF_FFFF;
      default: len_reg = $urandom_range(3 * caft_pkg::BLOCK_BYTES, caft_pkg::SEGMENT_BOUNDARY);
    endcase
    wait_idle();
    load_config(caft_pkg::MODE_BLOCK, rand_key(), rand_key(), rand_key(), rand_key(), len_reg);
    send_chunk(total);
    pair_chunks++;
  endtask

  task automatic run_traffic(input int unsigned send_idle, input int unsigned recv_stall,
                             input int unsigned pairs, input int unsigned short_items);
    int unsigned stop_at;
    wait_idle();
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    repeat (pairs) run_block_pair();
    stop_at = bytes_sent + short_items;
    while (bytes_sent < stop_at) begin
      wait_idle();
      load_config(2'($urandom_range(3)), rand_key(), rand_key(), rand_key(), rand_key(),
                  rand_len());
      repeat ($urandom_range(1, 3)) send_chunk($urandom_range(1, 32));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_pass();
    test_arx_extremes();
    test_spare_mode();
    test_block_edges();
    run_traffic(0, 0, 0, 30);
    run_traffic(88, 0, 0, 30);
    run_traffic(0, 88, 1, 8);
    run_traffic(26, 26, 1, 8);
    wait_idle();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    $display("sent %0d chunk bytes in all modes, %0d paired-block chunks, %0d results checked",
             bytes_sent, pair_chunks, results_checked);
    $display("idle phases: none, sender, receiver, both");
    if (error_count == 0 && transformed_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
